/* hdl/chunk_reassembly_tracker_assert.svh */
// Assertion macros for the checker file.
`ifndef CHUNK_REASSEMBLY_TRACKER_ASSERT_SVH
`define CHUNK_REASSEMBLY_TRACKER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define CRT_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// Implication whose right side is checked in the cycle after the left side holds.
`define CRT_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

/* hdl/crt_pkg.sv */
`default_nettype none
package crt_pkg;
   typedef enum logic [1:0] {
      OP_CHUNK   = 2'd0,
      OP_QUERY   = 2'd1,
      OP_RELEASE = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_ACCEPTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_BAD_CHUNK = 3'd2,
      ST_BOUNDS    = 3'd3,
      ST_INVALID   = 3'd4,
      ST_FULL      = 3'd5,
      ST_NOT_FOUND = 3'd6,
      ST_DONE      = 3'd7
   } status_type;

   localparam logic [0:0] CSR_MAX_CHUNK_BYTES  = 1'd0;
   localparam logic [0:0] CSR_MAX_TOTAL_LENGTH = 1'd1;
   localparam logic [15:0] RESET_MAX_CHUNK_BYTES  = 16'd476;
   localparam logic [23:0] RESET_MAX_TOTAL_LENGTH = 24'd8388608;
   localparam logic [6:0] PERCENT_FULL = 7'd100;
   localparam logic [6:0] PERCENT_CAP  = 7'd99;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] command_id;
      logic [15:0] total_chunks;
      logic [23:0] total_length;
      logic [15:0] chunk_number;
      logic [23:0] chunk_offset;
      logic [23:0] chunk_length;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  slot_index;
      logic [23:0] write_offset;
      logic [23:0] write_length;
      logic [6:0]  percent;
      logic        complete;
   } rsp_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_LOOKUP,
      BK_APPLY,
      BK_DIVIDE,
      BK_EMIT
   } back_state_type;
endpackage
`default_nettype wire

/* hdl/crt_if.sv */
`default_nettype none
interface crt_req_if;
   logic                 valid;
   logic                 ready;
   crt_pkg::req_type     payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface crt_rsp_if;
   logic                 valid;
   logic                 ready;
   crt_pkg::rsp_type     payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* hdl/crt_front.sv */
`default_nettype none
// Input stage: drops the unused operation code and queues items in a two entry FIFO.
module crt_front (
   input  wire logic              clock,
   input  wire logic              reset,
   crt_req_if.sink                req,
   output crt_pkg::req_type       q_data,
   output logic                   q_valid,
   input  wire logic              q_pop
);
   crt_pkg::req_type mem_ff [2];
   logic [0:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push;

   assign req.ready = (cnt_ff != 2'd2);
   assign push = req.valid && req.ready &&
      (req.payload.operation != crt_pkg::OP_NONE);
   assign q_valid = (cnt_ff != 2'd0);
   assign q_data = mem_ff[rp_ff];

   always_comb begin
      wp_in = wp_ff + 1'b1;
      rp_in = rp_ff + 1'b1;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_in;
         if (q_pop) rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= req.payload;
   end
endmodule
`default_nettype wire

/* hdl/crt_back.sv */
`default_nettype none
// Slot table, checks and progress divide, plus the output register.
module crt_back #(
   parameter int NUM_SLOTS = 8,
   parameter int MAX_CHUNKS = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  crt_pkg::req_type       q_data,
   input  wire logic              q_valid,
   output logic                   q_pop,
   input  wire logic [15:0]       max_chunk_bytes,
   input  wire logic [23:0]       max_total_length,
   crt_rsp_if.source              rsp
);
   localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CW = $clog2(MAX_CHUNKS + 1);
   localparam int MW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
   localparam int RW = CW + 7;

   logic [NUM_SLOTS-1:0]  used_ff, used_in;
   logic [NUM_SLOTS-1:0]  valid_ff;
   logic [15:0]           id_ff [NUM_SLOTS];
   logic [CW-1:0]         chunks_ff [NUM_SLOTS];
   logic [CW-1:0]         present_ff [NUM_SLOTS];
   logic [23:0]           length_ff [NUM_SLOTS];
   logic [MAX_CHUNKS-1:0] map_ff [NUM_SLOTS];

   crt_pkg::back_state_type state_ff, state_in;
   crt_pkg::req_type        item_ff;
   logic [SW-1:0]           slot_ff, slot_in;
   logic                    hit_ff, hit_in, free_ff, free_in;
   logic [39:0]             prod_ff;
   logic                    sv_ff, sv_in;
   logic [CW-1:0]           sc_ff, sc_in, sp_ff, sp_in;
   crt_pkg::rsp_type        out_ff, out_in;
   logic                    ov_ff;
   logic                    div_ff;
   logic [6:0]              num_cnt_ff;
   logic [RW-1:0]           rem_ff;
   logic [6:0]              quo_ff;
   logic [2:0]              div_step_ff;

   logic [SW-1:0] hit_idx, free_idx;
   logic hit_any, free_any;
   logic in_bad;
   logic wr_alloc, wr_set, wr_release;
   logic [MW-1:0] cbit;
   logic start_div, div_done;

   always_comb begin
      hit_any = 1'b0; free_any = 1'b0; hit_idx = '0; free_idx = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (used_ff[i] && id_ff[i] == item_ff.command_id) begin
            hit_any = 1'b1; hit_idx = SW'(i);
         end
         if (!used_ff[i]) begin
            free_any = 1'b1; free_idx = SW'(i);
         end
      end
   end

   assign in_bad = (item_ff.total_chunks == 16'd0) || (item_ff.total_length == 24'd0) ||
      (item_ff.total_length > max_total_length) ||
      ({8'd0, item_ff.total_chunks} > item_ff.total_length) ||
      ({16'd0, item_ff.total_length} > prod_ff) ||
      ({16'd0, item_ff.total_chunks} > 32'(MAX_CHUNKS));

   assign cbit = MW'(item_ff.chunk_number);
   assign rsp.valid = ov_ff;
   assign rsp.payload = out_ff;

   always_comb begin
      state_in = state_ff;
      q_pop = 1'b0;
      slot_in = slot_ff; hit_in = hit_ff; free_in = free_ff;
      sv_in = sv_ff; sc_in = sc_ff; sp_in = sp_ff;
      out_in = out_ff;
      wr_alloc = 1'b0; wr_set = 1'b0; wr_release = 1'b0;
      used_in = used_ff;
      start_div = 1'b0;
      case (state_ff)
         crt_pkg::BK_IDLE: begin
            if (q_valid && !ov_ff) begin
               q_pop = 1'b1;
               state_in = crt_pkg::BK_LOOKUP;
            end
         end
         crt_pkg::BK_LOOKUP: begin
            hit_in = hit_any; free_in = free_any;
            slot_in = hit_any ? hit_idx : free_idx;
            state_in = crt_pkg::BK_APPLY;
         end
         crt_pkg::BK_APPLY: begin
            out_in = '0;
            out_in.slot_index = 3'(slot_ff);
            state_in = crt_pkg::BK_EMIT;
            sv_in = valid_ff[slot_ff];
            sc_in = chunks_ff[slot_ff];
            sp_in = present_ff[slot_ff];
            case (crt_pkg::op_type'(item_ff.operation))
               crt_pkg::OP_QUERY: begin
                  if (!hit_ff) begin
                     out_in.status = crt_pkg::ST_NOT_FOUND;
                     out_in.slot_index = '0;
                  end else begin
                     start_div = 1'b1;
                     state_in = crt_pkg::BK_DIVIDE;
                  end
               end
               crt_pkg::OP_RELEASE: begin
                  if (!hit_ff) begin
                     out_in.status = crt_pkg::ST_NOT_FOUND;
                     out_in.slot_index = '0;
                  end else begin
                     used_in[slot_ff] = 1'b0;
                     out_in.status = crt_pkg::ST_ACCEPTED;
                  end
               end
               crt_pkg::OP_CHUNK: begin
                  if (!hit_ff && !free_ff) begin
                     out_in.status = crt_pkg::ST_FULL;
                     out_in.slot_index = '0;
                  end else begin
                     if (!hit_ff) begin
                        wr_alloc = 1'b1;
                        used_in[slot_ff] = 1'b1;
                        sv_in = !in_bad;
                        sc_in = in_bad ? '0 : CW'(item_ff.total_chunks);
                        sp_in = '0;
                     end
                     if (!sv_in) begin
                        out_in.status = crt_pkg::ST_INVALID;
                     end else begin
                        start_div = 1'b1;
                        state_in = crt_pkg::BK_DIVIDE;
                        if ({16'd0, item_ff.chunk_number} >= 32'(sc_in)) begin
                           out_in.status = crt_pkg::ST_BAD_CHUNK;
                        end else if (item_ff.chunk_length >
                              (hit_ff ? length_ff[slot_ff] : item_ff.total_length) ||
                              item_ff.chunk_offset >
                              (hit_ff ? length_ff[slot_ff] : item_ff.total_length) -
                              item_ff.chunk_length) begin
                           out_in.status = crt_pkg::ST_BOUNDS;
                        end else if (hit_ff && map_ff[slot_ff][cbit]) begin
                           out_in.status = crt_pkg::ST_DUPLICATE;
                        end else begin
                           wr_set = 1'b1;
                           sp_in = sp_in + 1'b1;
                           out_in.write_offset = item_ff.chunk_offset;
                           out_in.write_length = item_ff.chunk_length;
                           out_in.status = (sp_in == sc_in) ? crt_pkg::ST_DONE :
                              crt_pkg::ST_ACCEPTED;
                        end
                     end
                  end
               end
               default: begin
                  state_in = crt_pkg::BK_IDLE;
               end
            endcase
         end
         crt_pkg::BK_DIVIDE: begin
            if (div_done) begin
               state_in = crt_pkg::BK_EMIT;
               if (item_ff.operation == crt_pkg::OP_QUERY) begin
                  out_in.status = !sv_ff ? crt_pkg::ST_INVALID :
                     (sp_ff == sc_ff) ? crt_pkg::ST_DONE : crt_pkg::ST_ACCEPTED;
               end
               if (!sv_ff || sc_ff == '0) begin
                  out_in.percent = '0;
               end else if (sp_ff == sc_ff) begin
                  out_in.percent = crt_pkg::PERCENT_FULL;
               end else begin
                  out_in.percent = (quo_ff > crt_pkg::PERCENT_CAP) ?
                     crt_pkg::PERCENT_CAP : quo_ff;
               end
               out_in.complete = sv_ff && (sp_ff == sc_ff);
            end
         end
         crt_pkg::BK_EMIT: begin
            state_in = crt_pkg::BK_IDLE;
         end
         default: begin
            state_in = crt_pkg::BK_IDLE;
         end
      endcase
   end

   assign div_done = div_ff && (div_step_ff == 3'd0) && (num_cnt_ff == 7'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= crt_pkg::BK_IDLE;
         used_ff <= '0;
         ov_ff <= 1'b0;
         div_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         if (state_ff == crt_pkg::BK_EMIT) ov_ff <= 1'b1;
         else if (rsp.ready) ov_ff <= 1'b0;
         if (start_div) div_ff <= 1'b1;
         else if (div_done) div_ff <= 1'b0;
      end
   end

   // Restoring divide of present*100 by chunks, one quotient bit a cycle.
   always_ff @(posedge clock) begin
      item_ff <= (q_pop) ? q_data : item_ff;
      prod_ff <= {24'd0, item_ff.total_chunks} * {24'd0, max_chunk_bytes};
      slot_ff <= slot_in; hit_ff <= hit_in; free_ff <= free_in;
      sv_ff <= sv_in; sc_ff <= sc_in; sp_ff <= sp_in;
      out_ff <= out_in;
      if (start_div) begin
         num_cnt_ff <= 7'(sp_in * 7'd100 >> 0);
         rem_ff <= {7'd0, sp_in} * RW'(100);
         quo_ff <= '0;
         div_step_ff <= 3'd7;
      end else if (div_ff && div_step_ff != 3'd0) begin
         div_step_ff <= div_step_ff - 3'd1;
         num_cnt_ff <= 7'd0;
         quo_ff <= (rem_ff >= ({{7{1'b0}}, sc_ff} << (div_step_ff - 3'd1))) ?
            quo_ff | (7'd1 << (div_step_ff - 3'd1)) : quo_ff;
         rem_ff <= (rem_ff >= ({{7{1'b0}}, sc_ff} << (div_step_ff - 3'd1))) ?
            rem_ff - ({{7{1'b0}}, sc_ff} << (div_step_ff - 3'd1)) : rem_ff;
      end else begin
         num_cnt_ff <= 7'd0;
      end
      if (wr_alloc) begin
         id_ff[slot_ff] <= item_ff.command_id;
         valid_ff[slot_ff] <= sv_in;
         chunks_ff[slot_ff] <= sc_in;
         length_ff[slot_ff] <= in_bad ? 24'd0 : item_ff.total_length;
      end
      // A fresh slot starts with an empty map, holding only the first chunk if it is taken.
      if (wr_alloc) begin
         map_ff[slot_ff] <= wr_set ? (MAX_CHUNKS'(1) << cbit) : '0;
      end else if (wr_set) begin
         map_ff[slot_ff][cbit] <= 1'b1;
      end
      if (wr_alloc || wr_set) begin
         present_ff[slot_ff] <= sp_in;
      end
   end
endmodule
`default_nettype wire

/* hdl/chunk_reassembly_tracker.sv */
`default_nettype none
// Chunk reassembly tracker.
// Items arrive on req (valid/ready): chunk arrival, progress query or slot
// release, keyed by command id. Each item yields one result word on rsp:
// a status, the slot used, the write window of an accepted chunk, the
// progress percentage and a completion flag. Operation code three is
// dropped without a result.
// The csr port sets the largest chunk payload and total length; the user
// must write it only while the block is idle, the block does not enforce it.
// A two word queue decouples acceptance from the slot table engine. The
// engine takes a word from the queue when idle with no result waiting,
// then passes through lookup, apply and, for a query that finds its slot or
// a chunk on a valid slot, a seven step restoring divide for the percentage,
// then loads the result register. It takes its next word only after the
// result has been taken, so it works on one item at a time.
// A waiting result stalls the engine, the queue then fills and req.ready
// falls. Reset clears the queue, the slot usage bits and the result valid;
// slot contents are rewritten on allocation.
module chunk_reassembly_tracker #(
   parameter int NUM_SLOTS = 8,
   parameter int MAX_CHUNKS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   crt_req_if.sink          req,
   crt_rsp_if.source        rsp,
   input  wire logic        csr_write_enable,
   input  wire logic [0:0]  csr_index,
   input  wire logic [23:0] csr_write_data
);
   logic [15:0] max_chunk_bytes_ff;
   logic [23:0] max_total_length_ff;
   crt_pkg::req_type q_data;
   logic q_valid, q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_chunk_bytes_ff <= crt_pkg::RESET_MAX_CHUNK_BYTES;
         max_total_length_ff <= crt_pkg::RESET_MAX_TOTAL_LENGTH;
      end else if (csr_write_enable) begin
         if (csr_index == crt_pkg::CSR_MAX_CHUNK_BYTES)
            max_chunk_bytes_ff <= csr_write_data[15:0];
         else
            max_total_length_ff <= csr_write_data;
      end
   end

   crt_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
   );

   crt_back #(.NUM_SLOTS(NUM_SLOTS), .MAX_CHUNKS(MAX_CHUNKS)) u_back (
      .clock(clock), .reset(reset), .q_data(q_data), .q_valid(q_valid),
      .q_pop(q_pop), .max_chunk_bytes(max_chunk_bytes_ff),
      .max_total_length(max_total_length_ff), .rsp(rsp)
   );
endmodule
`default_nettype wire

/* hdl/crt_checker.sv */
`default_nettype none
`include "chunk_reassembly_tracker_assert.svh"
module crt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_status,
   input wire logic [6:0]  rsp_percent,
   input wire logic        rsp_complete,
   input wire logic [23:0] rsp_write_length
);
   `CRT_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `CRT_ASSERT_IMPL(a_pct, clock, reset, rsp_valid, rsp_percent <= crt_pkg::PERCENT_FULL)
   `CRT_ASSERT_IMPL(a_cmp, clock, reset, rsp_valid && rsp_complete, rsp_percent == crt_pkg::PERCENT_FULL)
   `CRT_ASSERT_IMPL(a_len, clock, reset, rsp_valid && rsp_write_length != 24'd0,
      rsp_status == crt_pkg::ST_ACCEPTED || rsp_status == crt_pkg::ST_DONE)
endmodule

bind chunk_reassembly_tracker crt_checker u_crt_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.payload.status), .rsp_percent(rsp.payload.percent),
   .rsp_complete(rsp.payload.complete), .rsp_write_length(rsp.payload.write_length)
);
`default_nettype wire

/* sim/tb_chunk_reassembly_tracker.sv */
`default_nettype none
module tb_chunk_reassembly_tracker;
   timeunit 1ns;
   timeprecision 1ps;

   // Table geometry of the block as instantiated.
   localparam int NUM_SLOTS = 8;
   localparam int MAX_CHUNKS = 64;
   // Items per configuration phase of the random part.
   localparam int PHASE_WORDS = 310;
   // Cycles allowed after the last result for any word still inside the block,
   // for instance an operation three word that produces nothing.
   localparam int DRAIN_CYCLES = 80;
   localparam int HOLD_CYCLES = 600;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [0:0] csr_index = '0;
   logic [23:0] csr_write_data = '0;

   crt_req_if req_ch ();
   crt_rsp_if rsp_ch ();

   chunk_reassembly_tracker DUT (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #6 clock = ~clock;

   // Words waiting to be offered, and the results the table model predicts.
   crt_pkg::req_type pending_words[$];
   crt_pkg::rsp_type predicted_rsp[$];
   int errors = 0;

   // Own copy of the slot table and of the two limits.
   logic [15:0] lim_chunk_bytes;
   logic [23:0] lim_total_length;
   bit slot_used_m[NUM_SLOTS];
   bit slot_valid_m[NUM_SLOTS];
   logic [15:0] slot_id_m[NUM_SLOTS];
   logic [6:0] slot_chunks_m[NUM_SLOTS];
   logic [6:0] slot_present_m[NUM_SLOTS];
   logic [23:0] slot_length_m[NUM_SLOTS];
   logic [63:0] slot_map_m[NUM_SLOTS];

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
   endtask

   function automatic bit slot_complete(input int s);
      return slot_valid_m[s] && slot_present_m[s] == slot_chunks_m[s];
   endfunction

   // Progress is truncated and held at 99 until the last chunk has come.
   function automatic logic [6:0] slot_progress(input int s);
      int p;
      if (!slot_valid_m[s] || slot_chunks_m[s] == 0) return '0;
      if (slot_complete(s)) return crt_pkg::PERCENT_FULL;
      p = (int'(slot_present_m[s]) * 100) / int'(slot_chunks_m[s]);
      return (p > 99) ? crt_pkg::PERCENT_CAP : 7'(p);
   endfunction

   // Applies one accepted word to the table copy and works out its result.
   task automatic track_word(input crt_pkg::req_type w, output bit has_rsp,
                             output crt_pkg::rsp_type o);
      int s;
      int f;
      bit bad;
      logic [39:0] cap;
      o = '0;
      has_rsp = 1'b1;
      s = -1;
      f = -1;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (slot_used_m[i] && slot_id_m[i] == w.command_id) s = i;
         if (!slot_used_m[i]) f = i;
      end
      if (w.operation == crt_pkg::OP_NONE) begin
         has_rsp = 1'b0;
      end else if (w.operation == crt_pkg::OP_QUERY) begin
         if (s < 0) begin
            o.status = crt_pkg::ST_NOT_FOUND;
         end else begin
            o.slot_index = 3'(s);
            o.status = slot_complete(s) ? crt_pkg::ST_DONE :
               (slot_valid_m[s] ? crt_pkg::ST_ACCEPTED : crt_pkg::ST_INVALID);
            o.percent = slot_progress(s);
            o.complete = slot_complete(s);
         end
      end else if (w.operation == crt_pkg::OP_RELEASE) begin
         if (s < 0) begin
            o.status = crt_pkg::ST_NOT_FOUND;
         end else begin
            slot_used_m[s] = 1'b0;
            o.status = crt_pkg::ST_ACCEPTED;
            o.slot_index = 3'(s);
         end
      end else if (s < 0 && f < 0) begin
         o.status = crt_pkg::ST_FULL;
      end else begin
         if (s < 0) begin
            // The header is judged once, when the slot is taken.
            s = f;
            cap = 40'(w.total_chunks) * 40'(lim_chunk_bytes);
            bad = w.total_chunks == 0 || w.total_length == 0 ||
                  w.total_length > lim_total_length ||
                  24'(w.total_chunks) > w.total_length ||
                  40'(w.total_length) > cap || w.total_chunks > MAX_CHUNKS;
            slot_used_m[s] = 1'b1;
            slot_id_m[s] = w.command_id;
            slot_present_m[s] = '0;
            slot_map_m[s] = '0;
            slot_valid_m[s] = !bad;
            slot_chunks_m[s] = bad ? '0 : 7'(w.total_chunks);
            slot_length_m[s] = bad ? '0 : w.total_length;
         end
         o.slot_index = 3'(s);
         if (!slot_valid_m[s]) begin
            o.status = crt_pkg::ST_INVALID;
         end else begin
            if (w.chunk_number >= 16'(slot_chunks_m[s])) begin
               o.status = crt_pkg::ST_BAD_CHUNK;
            end else if (w.chunk_length > slot_length_m[s] ||
                         w.chunk_offset > slot_length_m[s] - w.chunk_length) begin
               o.status = crt_pkg::ST_BOUNDS;
            end else if (slot_map_m[s][w.chunk_number[5:0]]) begin
               o.status = crt_pkg::ST_DUPLICATE;
            end else begin
               slot_map_m[s][w.chunk_number[5:0]] = 1'b1;
               slot_present_m[s] = slot_present_m[s] + 7'd1;
               o.status = slot_complete(s) ? crt_pkg::ST_DONE : crt_pkg::ST_ACCEPTED;
               o.write_offset = w.chunk_offset;
               o.write_length = w.chunk_length;
            end
            o.percent = slot_progress(s);
            o.complete = slot_complete(s);
         end
      end
   endtask

   // Sender: bursts of random length separated by random gaps. A word stays
   // on the channel until it is taken, and the model is updated at that edge.
   int burst_left = 0;
   int gap_left = 0;
   initial begin
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
   end

   always @(posedge clock) begin
      logic next_valid;
      crt_pkg::req_type next_word;
      bit has_rsp;
      crt_pkg::rsp_type r;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         next_valid = req_ch.valid;
         next_word = req_ch.payload;
         if (req_ch.valid && req_ch.ready) begin
            track_word(pending_words[0], has_rsp, r);
            if (has_rsp) predicted_rsp.push_back(r);
            void'(pending_words.pop_front());
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_words.size() > 0) begin
               next_valid = 1'b1;
               next_word = pending_words[0];
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(24, 1);
                  gap_left = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(10, 1);
               end else begin
                  burst_left--;
               end
            end
         end
         req_ch.valid <= next_valid;
         req_ch.payload <= next_word;
      end
   end

   // Long receiver hold-off, counted here once the stimulus asks for it.
   bit hold_request = 1'b0;
   bit hold_taken = 1'b0;
   int hold_left = 0;
   always @(posedge clock) begin
      if (hold_request && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Receiver: it switches at random among four stall patterns, and each result word
   // is checked against the oldest prediction as it is taken.
   int stall_mode = 0;
   int stall_count = 0;
   initial rsp_ch.ready = 1'b0;

   always @(posedge clock) begin
      crt_pkg::rsp_type e;
      crt_pkg::rsp_type g;
      bit rdy;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         g = rsp_ch.payload;
         if (predicted_rsp.size() == 0) begin
            report($sformatf("result word with nothing expected: %h", g));
         end else begin
            e = predicted_rsp.pop_front();
            if (g.status !== e.status)
               report($sformatf("status %0d, expected %0d", g.status, e.status));
            if (g.slot_index !== e.slot_index)
               report($sformatf("slot %0d, expected %0d", g.slot_index, e.slot_index));
            if (g.write_offset !== e.write_offset)
               report($sformatf("offset %0d, expected %0d", g.write_offset, e.write_offset));
            if (g.write_length !== e.write_length)
               report($sformatf("length %0d, expected %0d", g.write_length, e.write_length));
            if (g.percent !== e.percent)
               report($sformatf("percent %0d, expected %0d", g.percent, e.percent));
            if (g.complete !== e.complete)
               report($sformatf("complete %0d, expected %0d", g.complete, e.complete));
         end
      end
      stall_count++;
      if (stall_count % 97 == 0) stall_mode = $urandom_range(3, 0);
      case (stall_mode)
         0: rdy = 1'b1;
         1: rdy = 1'($urandom_range(1, 0));
         2: rdy = ($urandom_range(3, 0) == 0);
         default: rdy = (stall_count % 8) < 5;
      endcase
      rsp_ch.ready <= rdy && (hold_left == 0);
   end

   // Stimulus helpers.
   function automatic crt_pkg::req_type make_word(input crt_pkg::op_type op, input int id,
                                                  input int nch, input int tlen,
                                                  input int cnum, input int off,
                                                  input int len);
      crt_pkg::req_type w;
      w.operation = op;
      w.command_id = 16'(id);
      w.total_chunks = 16'(nch);
      w.total_length = 24'(tlen);
      w.chunk_number = 16'(cnum);
      w.chunk_offset = 24'(off);
      w.chunk_length = 24'(len);
      return w;
   endfunction

   function automatic int pick_id();
      return ($urandom_range(9, 0) == 0) ? (16'hFFFF - $urandom_range(3, 0))
                                          : $urandom_range(15, 0);
   endfunction

   task automatic write_limit(input logic [0:0] idx, input logic [23:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == crt_pkg::CSR_MAX_CHUNK_BYTES) lim_chunk_bytes = value[15:0];
      else lim_total_length = value;
   endtask

   task automatic wait_idle();
      while (pending_words.size() > 0 || req_ch.valid || predicted_rsp.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One command split into well-formed chunks in shuffled order, with the odd broken
   // or repeated chunk, maybe a query among them and usually a closing release.
   task automatic build_command(ref crt_pkg::req_type q[$]);
      crt_pkg::req_type w;
      crt_pkg::req_type tmp;
      int id, nch, tlen, off, ln, j;
      logic [39:0] hi;
      crt_pkg::req_type chunks[$];
      id = pick_id();
      nch = ($urandom_range(9, 0) == 0) ? $urandom_range(66, 1) : $urandom_range(6, 1);
      hi = 40'(nch) * 40'(lim_chunk_bytes);
      if (hi > 40'(lim_total_length)) hi = 40'(lim_total_length);
      tlen = (hi < 40'(nch)) ? nch : $urandom_range(int'(hi), nch);
      off = 0;
      for (int c = 0; c < nch; c++) begin
         ln = tlen / nch + ((c < tlen % nch) ? 1 : 0);
         w = make_word(crt_pkg::OP_CHUNK, id, nch, tlen, c, off, ln);
         off += ln;
         case ($urandom_range(19, 0))
            0: w.chunk_number = 16'(nch + $urandom_range(3, 0));
            1: w.chunk_length = w.chunk_length + 24'($urandom_range(100, 1));
            2: w.chunk_offset = 24'(tlen);
            3: chunks.push_back(w);
            default: ;
         endcase
         chunks.push_back(w);
      end
      for (int i = chunks.size() - 1; i > 0; i--) begin
         j = $urandom_range(i, 0);
         tmp = chunks[i];
         chunks[i] = chunks[j];
         chunks[j] = tmp;
      end
      if ($urandom_range(2, 0) == 0)
         chunks.insert($urandom_range(chunks.size(), 0),
                       make_word(crt_pkg::OP_QUERY, id, 0, 0, 0, 0, 0));
      if ($urandom_range(6, 0) != 0)
         chunks.push_back(make_word(crt_pkg::OP_RELEASE, id, 0, 0, 0, 0, 0));
      foreach (chunks[i]) q.push_back(chunks[i]);
   endtask

   // Mostly pairs of commands interleaved, the rest noise words.
   task automatic fill_phase(input int count);
      crt_pkg::req_type a[$];
      crt_pkg::req_type b[$];
      logic [127:0] noise;
      int added;
      added = 0;
      while (added < count) begin
         if ($urandom_range(3, 0) != 0) begin
            a.delete();
            b.delete();
            build_command(a);
            build_command(b);
            while (a.size() > 0 || b.size() > 0) begin
               if (b.size() == 0 || (a.size() > 0 && $urandom_range(1, 0)))
                  pending_words.push_back(a.pop_front());
               else
                  pending_words.push_back(b.pop_front());
               added++;
            end
         end else begin
            case ($urandom_range(2, 0))
               0: pending_words.push_back(
                     make_word(crt_pkg::OP_QUERY, pick_id(), 0, 0, 0, 0, 0));
               1: pending_words.push_back(
                     make_word(crt_pkg::OP_RELEASE, pick_id(), 0, 0, 0, 0, 0));
               default: begin
                  noise = {$urandom, $urandom, $urandom, $urandom};
                  pending_words.push_back(
                     crt_pkg::req_type'(noise[$bits(crt_pkg::req_type)-1:0]));
               end
            endcase
            added++;
         end
      end
   endtask

   initial begin
      lim_chunk_bytes = crt_pkg::RESET_MAX_CHUNK_BYTES;
      lim_total_length = crt_pkg::RESET_MAX_TOTAL_LENGTH;
      foreach (slot_used_m[i]) slot_used_m[i] = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset limits: every header rejection, every
      // chunk status, a full table, queries, releases and an ignored code.
      pending_words.push_back(make_word(crt_pkg::OP_CHUNK, 1, 0, 10, 0, 0, 1));      // no chunks
      pending_words.push_back(make_word(crt_pkg::OP_CHUNK, 2, 2, 0, 0, 0, 0));       // no length
      pending_words.push_back(make_word(crt_pkg::OP_CHUNK, 3, 1, 8388609, 0, 0, 1)); // too long
      pending_words.push_back(make_word(crt_pkg::OP_CHUNK, 4, 5, 3, 0, 0, 1));       // chunks > bytes
      pending_words.push_back(make_word(crt_pkg::OP_CHUNK, 5, 1, 477, 0, 0, 1));     // over chunk size
      pending_words.push_back(make_word(crt_pkg::OP_CHUNK, 6, 65, 1000, 0, 0, 1));   // too many chunks
      pending_words.push_back(make_word(crt_pkg::OP_CHUNK, 1, 1, 1, 0, 0, 1));       // invalid slot
      pending_words.push_back(make_word(crt_pkg::OP_CHUNK, 7, 2, 10, 2, 0, 5));      // bad number
      pending_words.push_back(make_word(crt_pkg::OP_CHUNK, 7, 2, 10, 0, 6, 5));      // out of bounds
      pending_words.push_back(make_word(crt_pkg::OP_CHUNK, 7, 2, 10, 0, 0, 11));     // too long chunk
      pending_words.push_back(make_word(crt_pkg::OP_CHUNK, 7, 2, 10, 0, 0, 5));
      pending_words.push_back(make_word(crt_pkg::OP_CHUNK, 7, 2, 10, 0, 0, 5));      // duplicate
      pending_words.push_back(make_word(crt_pkg::OP_CHUNK, 7, 2, 10, 1, 5, 5));      // completes
      pending_words.push_back(make_word(crt_pkg::OP_CHUNK, 7, 2, 10, 1, 5, 5));      // after done
      pending_words.push_back(
         make_word(crt_pkg::OP_CHUNK, 16'hFFFF, 64, 30464, 63, 30000, 464));
      pending_words.push_back(make_word(crt_pkg::OP_CHUNK, 0, 1, 1, 0, 0, 1));       // table full
      pending_words.push_back(make_word(crt_pkg::OP_QUERY, 7, 0, 0, 0, 0, 0));
      pending_words.push_back(make_word(crt_pkg::OP_QUERY, 1, 0, 0, 0, 0, 0));
      pending_words.push_back(make_word(crt_pkg::OP_QUERY, 16'hFFFF, 0, 0, 0, 0, 0));
      pending_words.push_back(make_word(crt_pkg::OP_QUERY, 9, 0, 0, 0, 0, 0));       // not found
      pending_words.push_back(make_word(crt_pkg::OP_RELEASE, 3, 0, 0, 0, 0, 0));
      pending_words.push_back(make_word(crt_pkg::OP_RELEASE, 3, 0, 0, 0, 0, 0));     // not found
      pending_words.push_back(make_word(crt_pkg::OP_NONE, 7, 1, 1, 0, 0, 0));        // ignored
      pending_words.push_back(make_word(crt_pkg::OP_QUERY, 7, 0, 0, 0, 0, 0));
      wait_idle();

      // Random phases, each under its own pair of limits, extremes included.
      write_limit(crt_pkg::CSR_MAX_CHUNK_BYTES, 24'd476);
      write_limit(crt_pkg::CSR_MAX_TOTAL_LENGTH, 24'd8388608);
      hold_request = 1'b1;   // the block fills up and stalls its input here
      fill_phase(PHASE_WORDS);
      wait_idle();
      write_limit(crt_pkg::CSR_MAX_CHUNK_BYTES, 24'd1);
      fill_phase(PHASE_WORDS);
      wait_idle();
      write_limit(crt_pkg::CSR_MAX_CHUNK_BYTES, 24'd65535);
      write_limit(crt_pkg::CSR_MAX_TOTAL_LENGTH, 24'd1);
      fill_phase(PHASE_WORDS);
      wait_idle();
      write_limit(crt_pkg::CSR_MAX_CHUNK_BYTES, 24'd100);
      write_limit(crt_pkg::CSR_MAX_TOTAL_LENGTH, 24'd3000);
      fill_phase(PHASE_WORDS);
      wait_idle();
      write_limit(crt_pkg::CSR_MAX_TOTAL_LENGTH, 24'd8388608);
      fill_phase(PHASE_WORDS);
      wait_idle();

      if (predicted_rsp.size() != 0) report("predicted results left over");
      if (errors == 0) begin
         $display("chunk_reassembly_tracker test passed");
      end else begin
         $display("chunk_reassembly_tracker test failed");
      end
      $finish;
   end

   // Watchdog for a block that stops answering.
   initial begin
      #10ms;
      $display("chunk_reassembly_tracker test failed");
      $finish;
   end
endmodule
`default_nettype wire
